>>> design/ibl_pkg.sv
package ibl_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned POS_W = 7;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W = 7;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] data_in;
  } in_t;

  typedef struct packed {
    logic              ok;
    logic [BYTE_W-1:0] data_out;
    logic [LEN_W-1:0]  length;
  } out_t;

endpackage

>>> design/ibl_mem.sv
module ibl_mem #(
  parameter int unsigned DEPTH = ibl_pkg::CAPACITY_DEF,
  parameter int unsigned AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [ibl_pkg::BYTE_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [ibl_pkg::BYTE_W-1:0] rdata
);
  import ibl_pkg::*;

  logic [BYTE_W-1:0] mem_r [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/ibl_ctrl.sv
module ibl_ctrl #(
  parameter int unsigned CAPACITY = ibl_pkg::CAPACITY_DEF,
  parameter int unsigned AW = $clog2(CAPACITY),
  parameter int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ibl_pkg::in_t               in_data,
  output logic                       res_valid,
  input  logic                       res_ready,
  output ibl_pkg::out_t              res,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [ibl_pkg::BYTE_W-1:0] mem_wdata,
  output logic                       mem_re,
  output logic [AW-1:0]              mem_raddr,
  input  logic [ibl_pkg::BYTE_W-1:0] mem_rdata
);
  import ibl_pkg::*;

  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_RWAIT = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     used_r, used_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [AW-1:0]     stop_r, stop_nxt;
  logic [AW-1:0]     wa_r, wa_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [BYTE_W-1:0] rd_r, rd_nxt;
  logic              ins_r, ins_nxt;
  logic              ok_r, ok_nxt;
  logic              rvalid_r, rvalid_nxt;

  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] used_ext;
  logic [CMPW-1:0] cap_ext;
  logic [CMPW-1:0] used_m1;
  logic [CMPW-1:0] pos_p1;
  logic            accept;

  assign pos_ext  = CMPW'(in_data.position);
  assign used_ext = CMPW'(used_r);
  assign cap_ext  = CMPW'(CAPACITY);
  assign used_m1  = used_ext - CMPW'(1);
  assign pos_p1   = pos_ext + CMPW'(1);
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt  = state_r;
    used_nxt   = used_r;
    ptr_nxt    = ptr_r;
    stop_nxt   = stop_r;
    wa_nxt     = wa_r;
    pos_nxt    = pos_r;
    byte_nxt   = byte_r;
    rd_nxt     = rd_r;
    ins_nxt    = ins_r;
    ok_nxt     = ok_r;
    rvalid_nxt = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = ptr_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ok_nxt    = 1'b0;
          rd_nxt    = '0;
          state_nxt = S_OUT;
          pos_nxt   = pos_ext[AW-1:0];
          byte_nxt  = in_data.data_in;
          case (in_data.kind)
            KIND_INSERT: begin
              if (pos_ext <= used_ext && used_ext < cap_ext) begin
                ok_nxt   = 1'b1;
                used_nxt = used_r + CW'(1);
                ins_nxt  = 1'b1;
                if (pos_ext == used_ext) begin
                  state_nxt = S_PUT;
                end else begin
                  ptr_nxt   = used_m1[AW-1:0];
                  stop_nxt  = pos_ext[AW-1:0];
                  state_nxt = S_SHIFT;
                end
              end
            end
            KIND_DELETE: begin
              if (pos_ext < used_ext) begin
                ok_nxt   = 1'b1;
                used_nxt = used_r - CW'(1);
                ins_nxt  = 1'b0;
                if (pos_ext != used_m1) begin
                  ptr_nxt   = pos_p1[AW-1:0];
                  stop_nxt  = used_m1[AW-1:0];
                  state_nxt = S_SHIFT;
                end
              end
            end
            KIND_READ: begin
              if (pos_ext < used_ext) begin
                ok_nxt    = 1'b1;
                state_nxt = S_READ;
              end
            end
            default: begin
              ok_nxt   = 1'b1;
              used_nxt = '0;
            end
          endcase
        end
      end
      S_SHIFT: begin
        mem_re     = 1'b1;
        mem_raddr  = ptr_r;
        rvalid_nxt = 1'b1;
        wa_nxt     = ins_r ? ptr_r + AW'(1) : ptr_r - AW'(1);
        if (ptr_r == stop_r) begin
          state_nxt = S_FLUSH;
        end else begin
          ptr_nxt = ins_r ? ptr_r - AW'(1) : ptr_r + AW'(1);
        end
      end
      S_FLUSH: begin
        state_nxt = ins_r ? S_PUT : S_OUT;
      end
      S_PUT: begin
        state_nxt = S_OUT;
      end
      S_READ: begin
        mem_re    = 1'b1;
        mem_raddr = pos_r;
        state_nxt = S_RWAIT;
      end
      S_RWAIT: begin
        rd_nxt    = mem_rdata;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_we    = rvalid_r;
    mem_waddr = wa_r;
    mem_wdata = mem_rdata;
    if (state_r == S_PUT) begin
      mem_we    = 1'b1;
      mem_waddr = pos_r;
      mem_wdata = byte_r;
    end
  end

  assign res_valid     = (state_r == S_OUT);
  assign res.ok        = ok_r;
  assign res.data_out  = rd_r;
  assign res.length    = used_ext[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      used_r   <= '0;
      rvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      rvalid_r <= rvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    stop_r <= stop_nxt;
    wa_r   <= wa_nxt;
    pos_r  <= pos_nxt;
    byte_r <= byte_nxt;
    rd_r   <= rd_nxt;
    ins_r  <= ins_nxt;
    ok_r   <= ok_nxt;
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_ext <= cap_ext)
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("accepted transaction left sequencer idle");

  a_flush_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FLUSH |-> rvalid_r)
    else $error("flush without pending move");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> CMPW'(ptr_r) <= used_ext)
    else $error("shift pointer beyond list");

  a_put_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PUT |-> !rvalid_r)
    else $error("insert write collides with pending move");

endmodule

>>> design/indexed_byte_list.sv
// Ordered list of up to CAPACITY bytes kept in a single-port-write, registered-read
// memory. One transaction at a time: in_stall stays high from acceptance until the
// result has been handed to the output register. Insert and delete move one entry per
// cycle through the memory's read and write ports, after which an insert writes the
// new byte at its position; a read makes one registered memory read. The output
// register holds one finished result, so a stalled consumer does not block the next
// transaction from starting.
module indexed_byte_list #(
  parameter int unsigned CAPACITY = ibl_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ibl_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ibl_pkg::out_t out_data
);
  import ibl_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  logic res_valid;
  logic res_ready;
  out_t res;

  logic out_valid_r;
  out_t out_data_r;

  ibl_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ibl_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
